FILE: hdl/ipv4v_pkg.sv
// ----------------------------------------------------------------------------
// ipv4v_pkg
// Shared types and constants for the dotted-quad address validator.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

  localparam logic [4:0] LEN_MIN   = 5'd7;
  localparam logic [4:0] LEN_MAX   = 5'd15;
  localparam logic [4:0] LEN_SAT   = 5'd16;
  localparam logic [9:0] OCTET_MAX = 10'd255;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;

  localparam logic [1:0] OCTET_LAST  = 2'd3;
  localparam logic [1:0] DIGITS_FULL = 2'd3;

  typedef enum logic [1:0] {
    REASON_OK     = 2'd0,
    REASON_LENGTH = 2'd1,
    REASON_FORMAT = 2'd2,
    REASON_VALUE  = 2'd3
  } reason_t;

  typedef struct packed {
    logic [4:0]  char_count;
    logic [1:0]  octet_index;
    logic [1:0]  digit_count;
    logic [9:0]  octet_value;
    logic [23:0] address_acc;
    logic        format_error;
    logic        range_error;
  } parse_state_t;

  typedef struct packed {
    logic        valid_res;
    reason_t     reason;
    logic [31:0] address;
  } verdict_t;

endpackage

FILE: hdl/ipv4v_if.sv
// ----------------------------------------------------------------------------
// ipv4v_in_if / ipv4v_out_if
// Valid/ready channels for characters in and verdicts out.
// ----------------------------------------------------------------------------
interface ipv4v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface ipv4v_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [1:0]  reason;
  logic [31:0] address;

  modport source (output valid, output valid_res, output reason, output address, input ready);
  modport sink   (input valid, input valid_res, input reason, input address, output ready);
endinterface

FILE: hdl/ipv4v_step.sv
// ----------------------------------------------------------------------------
// ipv4v_step
// One character of parsing: next parse state and, on the last character,
// the verdict.
// ----------------------------------------------------------------------------
module ipv4v_step (
  input  ipv4v_pkg::parse_state_t st,
  input  logic [7:0]              char_code,
  input  logic                    last,
  output ipv4v_pkg::parse_state_t st_nxt,
  output ipv4v_pkg::verdict_t     verdict
);

  ipv4v_pkg::parse_state_t n;
  logic                    is_digit;
  logic                    fe_end;
  logic                    re_end;
  ipv4v_pkg::reason_t      reason;

  always_comb begin
    n        = st;
    is_digit = (char_code >= ipv4v_pkg::CHAR_ZERO) && (char_code <= ipv4v_pkg::CHAR_NINE);

    if (st.char_count < ipv4v_pkg::LEN_SAT) begin
      n.char_count = st.char_count + 5'd1;
    end

    // octet counters freeze once the format is broken
    if (!st.format_error) begin
      if (is_digit) begin
        if (st.digit_count == ipv4v_pkg::DIGITS_FULL) begin
          n.format_error = 1'b1;
        end else begin
          n.octet_value = 10'(st.octet_value * 10'd10) + {6'd0, char_code[3:0]};
          n.digit_count = st.digit_count + 2'd1;
        end
      end else if (char_code == ipv4v_pkg::CHAR_DOT) begin
        if ((st.digit_count == 2'd0) || (st.octet_index == ipv4v_pkg::OCTET_LAST)) begin
          n.format_error = 1'b1;
        end else begin
          if ((st.octet_value > ipv4v_pkg::OCTET_MAX) ||
              ((st.octet_index == 2'd0) && (st.octet_value == 10'd0))) begin
            n.range_error = 1'b1;
          end
          n.address_acc = {st.address_acc[15:0], st.octet_value[7:0]};
          n.octet_index = st.octet_index + 2'd1;
          n.octet_value = 10'd0;
          n.digit_count = 2'd0;
        end
      end else begin
        n.format_error = 1'b1;
      end
    end

    // end-of-string checks on the fourth octet
    fe_end = n.format_error;
    re_end = n.range_error;
    if (!n.format_error) begin
      if ((n.digit_count == 2'd0) || (n.octet_index != ipv4v_pkg::OCTET_LAST)) begin
        fe_end = 1'b1;
      end else if (n.octet_value > ipv4v_pkg::OCTET_MAX) begin
        re_end = 1'b1;
      end
    end

    if ((n.char_count < ipv4v_pkg::LEN_MIN) || (n.char_count > ipv4v_pkg::LEN_MAX)) begin
      reason = ipv4v_pkg::REASON_LENGTH;
    end else if (fe_end) begin
      reason = ipv4v_pkg::REASON_FORMAT;
    end else if (re_end) begin
      reason = ipv4v_pkg::REASON_VALUE;
    end else begin
      reason = ipv4v_pkg::REASON_OK;
    end

    verdict.reason    = reason;
    verdict.valid_res = (reason == ipv4v_pkg::REASON_OK);
    verdict.address   = (reason == ipv4v_pkg::REASON_OK) ?
                        {n.address_acc, n.octet_value[7:0]} : 32'd0;

    st_nxt = last ? '0 : n;
  end

endmodule

FILE: hdl/ipv4_dotted_quad_validator_core.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_validator_core
// Streaming check of a dotted-quad address string, one character per cycle.
//
//   channel | dir | payload                      | transaction
//   in_ch   | in  | char_code[7:0], last         | one character
//   out_ch  | out | valid_res, reason[1:0],      | one verdict per string,
//           |     | address[31:0]                | issued on the last char
//
// One character accepted per cycle unless a last character waits on a stalled
// verdict; the verdict passes input register, parse step, result register.
// Throughput is set by the single parse-state update per character.
// Synchronous active-low reset clears the parse state and all valid flags.
// A stalled verdict holds the stage behind it only when that stage has
// another last character to deliver; other characters keep flowing.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_validator_core (
  input  logic                clk,
  input  logic                rst_n,
  ipv4v_in_if.sink            in_ch,
  ipv4v_out_if.source         out_ch
);

  logic                    s1_valid_r;
  logic [7:0]              s1_char_r;
  logic                    s1_last_r;
  ipv4v_pkg::parse_state_t state_r;
  ipv4v_pkg::parse_state_t state_nxt;
  ipv4v_pkg::verdict_t     verdict;
  logic                    out_valid_r;
  ipv4v_pkg::verdict_t     out_r;
  logic                    out_free;
  logic                    advance;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || advance;

  ipv4v_step u_step (
    .st        (state_r),
    .char_code (s1_char_r),
    .last      (s1_last_r),
    .st_nxt    (state_nxt),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char_r <= in_ch.char_code;
      s1_last_r <= in_ch.last;
    end
    if (advance && s1_last_r) begin
      out_r <= verdict;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.valid_res = out_r.valid_res;
  assign out_ch.reason    = out_r.reason;
  assign out_ch.address   = out_r.address;

endmodule
